FILE: src/dwq_pkg.sv
// dwq_pkg: shared widths, operation and status codes, and the result type
// for the de-duplicating work queue. No dependencies.
package dwq_pkg;

  // Payload widths
  localparam int ADDR_W   = 64;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  // Default table size
  localparam int DEFAULT_TABLE_DEPTH = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESET = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
  localparam logic [OP_W-1:0] OP_GET   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_RESET   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_PENDING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANDLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_GOT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd5;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   address_out;
  } res_t;

endpackage

FILE: src/dwq_if.sv
// dwq_if: valid/ready channel interfaces for the work queue's input and
// result transactions. Depends on dwq_pkg for payload widths.
interface dwq_in_if import dwq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface dwq_out_if import dwq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address_out;

  modport source (output valid, output status, output address_out, input ready);
  modport sink   (input valid, input status, input address_out, output ready);
endinterface

FILE: src/dwq_store.sv
// dwq_store: single-port-write, single-port-read address table with a
// registered read. Depends on dwq_pkg.
module dwq_store import dwq_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IdxW = $clog2(TABLE_DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IdxW-1:0]   rd_idx,
  output logic [ADDR_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IdxW-1:0]   wr_idx,
  input  logic [ADDR_W-1:0] wr_data
);

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/dwq_ctrl.sv
// dwq_ctrl: sequencer for reset, add (linear scan + append) and get
// transactions; owns entry count and head index. Depends on dwq_pkg.
module dwq_ctrl import dwq_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
  localparam int IdxW = $clog2(TABLE_DEPTH),
  localparam int CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // input transaction
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [ADDR_W-1:0] in_address,
  // table access
  output logic              rd_en,
  output logic [IdxW-1:0]   rd_idx,
  input  logic [ADDR_W-1:0] rd_data,
  output logic              wr_en,
  output logic [IdxW-1:0]   wr_idx,
  output logic [ADDR_W-1:0] wr_data,
  // result hand-off
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_GET,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [CntW-1:0]   pend_r, pend_nxt;
  logic [IdxW-1:0]   scan_idx_r, scan_idx_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  res_t              res_r, res_nxt;
  logic [CntW-1:0]   scan_next;

  assign scan_next = CntW'(scan_idx_r) + CntW'(1);

  // Next-state and table access
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pend_nxt     = pend_r;
    scan_idx_nxt = scan_idx_r;
    addr_nxt     = addr_r;
    res_nxt      = res_r;
    rd_en        = 1'b0;
    rd_idx       = scan_idx_r;
    wr_en        = 1'b0;
    wr_idx       = '0;
    wr_data      = addr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt  = in_address;
          res_nxt   = '{status: ST_NONE, address_out: '0};
          state_nxt = S_RESP;
          unique case (in_opcode)
            OP_RESET: begin
              // root goes to entry 0, already handled
              wr_en          = 1'b1;
              wr_idx         = '0;
              wr_data        = in_address;
              count_nxt      = CntW'(1);
              pend_nxt       = CntW'(1);
              res_nxt.status = ST_RESET;
            end
            OP_ADD: begin
              if (count_r == '0) begin
                // empty table: append at once
                wr_en          = 1'b1;
                wr_idx         = '0;
                wr_data        = in_address;
                count_nxt      = CntW'(1);
                res_nxt.status = ST_ADDED;
              end else begin
                rd_en        = 1'b1;
                rd_idx       = '0;
                scan_idx_nxt = '0;
                state_nxt    = S_SCAN;
              end
            end
            OP_GET: begin
              if (pend_r < count_r) begin
                rd_en     = 1'b1;
                rd_idx    = pend_r[IdxW-1:0];
                state_nxt = S_GET;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // compare entry scan_idx_r, prefetch the following one
        if (rd_data == addr_r) begin
          res_nxt.status = (CntW'(scan_idx_r) < pend_r) ? ST_HANDLED : ST_PENDING;
          state_nxt      = S_RESP;
        end else if (scan_next < count_r) begin
          rd_en        = 1'b1;
          rd_idx       = scan_next[IdxW-1:0];
          scan_idx_nxt = scan_next[IdxW-1:0];
        end else if (count_r < CntW'(TABLE_DEPTH)) begin
          wr_en          = 1'b1;
          wr_idx         = count_r[IdxW-1:0];
          wr_data        = addr_r;
          count_nxt      = count_r + CntW'(1);
          res_nxt.status = ST_ADDED;
          state_nxt      = S_RESP;
        end else begin
          res_nxt.status = ST_NONE;
          state_nxt      = S_RESP;
        end
      end

      S_GET: begin
        res_nxt.status      = ST_GOT;
        res_nxt.address_out = rd_data;
        pend_nxt            = pend_r + CntW'(1);
        state_nxt           = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    scan_idx_r <= scan_idx_nxt;
    res_r      <= res_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  assign res       = res_r;

endmodule

FILE: src/dwq_out_stage.sv
// dwq_out_stage: output register for result transactions, so the sequencer
// can take a new item while a result waits. Depends on dwq_pkg.
module dwq_out_stage import dwq_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  output logic                res_ready,
  input  res_t                res,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [ADDR_W-1:0]   out_address_out
);

  logic valid_r;
  res_t data_r;

  // slot is free when empty or being drained this cycle
  assign res_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = data_r.status;
  assign out_address_out = data_r.address_out;

endmodule

FILE: src/dedup_work_queue_unit.sv
// Reset, no-op, empty get and an add to an empty table go straight to the result;
// a get that hands out an address first reads its table entry; any other add scans
// the stored entries from entry 0 until it hits or has passed the last stored
// entry, the scan reading one table entry per cycle through the single read port.
// One item at a time: the next item is taken once the result enters the
// output register.
// rst_n clears count, head index, sequencer state and output valid; table
// contents are not cleared.
// Top level of the de-duplicating work queue; depends on dwq_pkg, dwq_if,
// dwq_store, dwq_ctrl and dwq_out_stage.
module dedup_work_queue_unit import dwq_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  dwq_in_if.sink     in_chan,
  dwq_out_if.source  out_chan
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  logic              rd_en;
  logic [IdxW-1:0]   rd_idx;
  logic [ADDR_W-1:0] rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_idx;
  logic [ADDR_W-1:0] wr_data;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  // Address table
  dwq_store #(.TABLE_DEPTH(TABLE_DEPTH)) u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data)
  );

  // Sequencer
  dwq_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_opcode  (in_chan.opcode),
    .in_address (in_chan.address),
    .rd_en      (rd_en),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Result register
  dwq_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_status      (out_chan.status),
    .out_address_out (out_chan.address_out)
  );

endmodule

FILE: src/dwq_checker.sv
// dwq_checker: port-level assertions for the work queue, bound to the top
// level. Depends on dwq_pkg and dedup_work_queue_unit.
module dwq_checker import dwq_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] out_status,
  input logic [ADDR_W-1:0]   out_address_out
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_address_out))
    else $error("result payload changed while stalled");

  // only defined status codes leave the block
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_NONE)
    else $error("undefined status code");

  // address is only carried by a successful get
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GOT) |-> out_address_out == '0)
    else $error("nonzero address on non-get result");

  // one transaction in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

endmodule

bind dedup_work_queue_unit dwq_checker u_dwq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_address_out (out_chan.address_out)
);
